/* rtl/bitstream_field_reader_macros.svh */
// Assertion helpers for the bit reader.
`ifndef BITSTREAM_FIELD_READER_MACROS_SVH
`define BITSTREAM_FIELD_READER_MACROS_SVH

// same-cycle implication
`define BFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/bfr_pkg.sv */
package bfr_pkg;

  localparam int ADDR_W  = 12;
  localparam int CNT_W   = 15;
  localparam int FIELD_W = 17;

  // bit_count range expressed in bytes, and as a bit span
  localparam logic [12:0] BACK_BYTES = 13'd4096;
  localparam logic [15:0] BACK_SPAN  = 16'h8000;

  localparam logic [4:0] WIN_BITS = 5'd24;

  typedef enum logic [2:0] {
    REQ_LOAD      = 3'd0,
    REQ_SET_POS   = 3'd1,
    REQ_READ_BITS = 3'd2,
    REQ_READ_BYTE = 3'd3,
    REQ_BACK_BITS = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_BITS,
    SEL_BYTE
  } sel_t;

endpackage

/* rtl/bitstream_field_reader.sv */
// MSB-first bit reader over a byte buffer.
// Request channel: req_valid / req_stall, fields req_type, bit_count,
// byte_address, load_data. Result channel: res_valid / res_stall, fields
// field_value, bits_to_boundary, read_error. Every request beat gives
// exactly one result beat, in order.
// A request passes through the read stage into the result register.
// Throughput: one request per cycle while req_stall is low. The byte
// position and bit index are updated at accept time without the buffer
// data; the data comes from two banks of 16-bit words (even and odd words)
// read in the accept cycle, so the three window bytes are always covered by
// one read of each bank. Extraction works on the registered bank words and
// lands in the result register when the read stage advances.
// BUFFER_BYTES must be a power of two.
// Reset clears the position, the bit index and all valid flags; buffer
// contents are undefined until loaded.
// When res_stall is high the result holds and one more request can be
// taken into the read stage; after that req_stall rises until the result
// is taken.
`include "bitstream_field_reader_macros.svh"

module bitstream_field_reader #(
  parameter int BUFFER_BYTES  = 4096,
  parameter int MAX_READ_BITS = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [2:0]                   req_type,
  input  logic [bfr_pkg::CNT_W-1:0]    bit_count,
  input  logic [bfr_pkg::ADDR_W-1:0]   byte_address,
  input  logic [7:0]                   load_data,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [bfr_pkg::FIELD_W-1:0]  field_value,
  output logic [2:0]                   bits_to_boundary,
  output logic                         read_error
);

  import bfr_pkg::*;

  localparam int AW    = $clog2(BUFFER_BYTES);
  localparam int DEPTH = BUFFER_BYTES / 4;
  localparam int IW    = (AW > 2) ? AW - 2 : 1;
  localparam int WW    = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int BW    = (AW > 13) ? AW : 13;

  // bank memories: word {byte 2w, byte 2w+1}, lane 1 holds the lower address
  logic [1:0][7:0] even_mem [DEPTH];
  logic [1:0][7:0] odd_mem  [DEPTH];
  logic [15:0]     even_q;
  logic [15:0]     odd_q;

  logic [AW-1:0] pos;
  logic [AW-1:0] pos_next;
  logic [2:0]    bi;
  logic [2:0]    bi_next;

  logic          accept;
  logic          s1_adv;
  logic          s1_valid;
  sel_t          s1_sel;
  logic [4:0]    s1_cnt;
  logic [2:0]    s1_bi;
  logic [1:0]    s1_lo;
  logic [2:0]    s1_btb;
  logic          s1_err;

  sel_t          sel_next;
  logic          err_next;
  logic          rd_ok;
  logic [WW-1:0] addr_ext;
  logic [AW-1:0] addr_mod;
  logic [AW-1:0] pos_plus2;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] even_idx;
  logic [IW-1:0] odd_idx;
  logic          wr_lane;
  logic [4:0]    adv;
  logic [15:0]   back_t;
  logic [BW-1:0] back_sum;

  logic [31:0]   w32;
  logic [23:0]   win24;
  logic [23:0]   win_sh;
  logic [23:0]   bits_sh;
  logic [FIELD_W-1:0] value_s1;

  assign s1_adv    = s1_valid && (!res_valid || !res_stall);
  assign req_stall = s1_valid && !s1_adv;
  assign accept    = req_valid && !req_stall;

  assign addr_ext  = WW'(byte_address);
  assign addr_mod  = addr_ext[AW-1:0];
  assign wr_idx    = IW'(addr_mod >> 2);
  assign wr_lane   = ~addr_mod[0];
  assign pos_plus2 = pos + AW'(2);
  assign even_idx  = IW'(pos_plus2 >> 2);
  assign odd_idx   = IW'(pos >> 2);

  assign rd_ok    = (bit_count != '0) && (bit_count <= CNT_W'(MAX_READ_BITS));
  assign adv      = 5'(bi) + bit_count[4:0];
  assign back_t   = 16'(bi) + BACK_SPAN - 16'(bit_count);
  assign back_sum = BW'(pos) + BW'(back_t[15:3]) - BW'(BACK_BYTES);

  always_comb begin
    pos_next = pos;
    bi_next  = bi;
    sel_next = SEL_ZERO;
    err_next = 1'b0;
    case (req_type)
      REQ_LOAD: begin
      end
      REQ_SET_POS: begin
        pos_next = addr_mod;
      end
      REQ_READ_BITS: begin
        if (bit_count > CNT_W'(MAX_READ_BITS)) begin
          err_next = 1'b1;
        end else if (rd_ok) begin
          sel_next = SEL_BITS;
          pos_next = pos + AW'(adv[4:3]);
          bi_next  = adv[2:0];
        end
      end
      REQ_READ_BYTE: begin
        sel_next = SEL_BYTE;
        pos_next = pos + AW'(1);
      end
      REQ_BACK_BITS: begin
        pos_next = back_sum[AW-1:0];
        bi_next  = back_t[2:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (req_type == REQ_LOAD && !addr_mod[1]) begin
        even_mem[wr_idx][wr_lane] <= load_data;
      end
      even_q <= even_mem[even_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (req_type == REQ_LOAD && addr_mod[1]) begin
        odd_mem[wr_idx][wr_lane] <= load_data;
      end
      odd_q <= odd_mem[odd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      bi       <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos      <= pos_next;
        bi       <= bi_next;
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sel <= sel_next;
      s1_err <= err_next;
      s1_cnt <= bit_count[4:0];
      s1_bi  <= bi;
      s1_lo  <= pos[1:0];
      s1_btb <= 3'(-bi_next);
    end
  end

  // window extraction
  assign w32     = s1_lo[1] ? {odd_q, even_q} : {even_q, odd_q};
  assign win24   = s1_lo[0] ? w32[23:0] : w32[31:8];
  assign win_sh  = win24 << s1_bi;
  assign bits_sh = win_sh >> (WIN_BITS - s1_cnt);

  always_comb begin
    case (s1_sel)
      SEL_BITS: value_s1 = bits_sh[FIELD_W-1:0];
      SEL_BYTE: value_s1 = FIELD_W'(win24[23:16]);
      default:  value_s1 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      field_value      <= value_s1;
      bits_to_boundary <= s1_btb;
      read_error       <= s1_err;
    end
  end

  `BFR_ASSERT_NEXT(a_err_no_move, accept && err_next, $stable(pos) && $stable(bi))
  `BFR_ASSERT_NOW(a_err_zero_value, s1_valid && s1_err, s1_sel == SEL_ZERO)
  `BFR_ASSERT_NEXT(a_drain, res_valid && !res_stall && !s1_adv, !res_valid)

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import bfr_pkg::*;

  localparam int          READ_BITS_MAX = 17;
  localparam int          CNT_MAX       = (1 << CNT_W) - 1;
  localparam logic [2:0]  REQ_CODE_MAX  = 3'd7;
  localparam int          GAP_MAX       = 4;
  localparam int          TAIL_CYCLES   = 8;
  localparam int          CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic [2:0]         boundary;
    logic               err;
  } field_result_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [2:0]         req_type = REQ_LOAD;
  logic [CNT_W-1:0]   bit_count = '0;
  logic [ADDR_W-1:0]  byte_address = '0;
  logic [7:0]         load_data = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [FIELD_W-1:0] field_value;
  logic [2:0]         bits_to_boundary;
  logic               read_error;

  // reader state as the block should hold it
  logic [7:0]        shadow_mem [0:(1 << ADDR_W)-1];
  bit                shadow_loaded [0:(1 << ADDR_W)-1];
  logic [ADDR_W-1:0] shadow_pos = '0;
  logic [2:0]        shadow_bit = '0;

  field_result_t pending_fields [$];
  int  mismatch_count = 0;
  int  beats_sent = 0;
  int  results_checked = 0;
  int  cycle_count = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  int  hold_off_left = 0;

  bitstream_field_reader DUT (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req_type         (req_type),
    .bit_count        (bit_count),
    .byte_address     (byte_address),
    .load_data        (load_data),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .field_value      (field_value),
    .bits_to_boundary (bits_to_boundary),
    .read_error       (read_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[bitstream_field_reader] ERROR");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic void predict_field_result(logic [2:0] code, logic [CNT_W-1:0] cnt,
                                               logic [ADDR_W-1:0] addr, logic [7:0] data);
    field_result_t      r;
    logic [23:0]        win;
    logic [CNT_W-1:0]   ptr;
    r = '0;
    ptr = {shadow_pos, shadow_bit};
    case (code)
      REQ_LOAD: begin
        shadow_mem[addr] = data;
        shadow_loaded[addr] = 1'b1;
      end
      REQ_SET_POS: shadow_pos = addr;
      REQ_READ_BITS: begin
        if (cnt > READ_BITS_MAX) begin
          r.err = 1'b1;
        end else if (cnt != 0) begin
          win = {shadow_mem[shadow_pos], shadow_mem[shadow_pos + 12'd1],
                 shadow_mem[shadow_pos + 12'd2]} << shadow_bit;
          r.value = FIELD_W'(win >> (24 - cnt));
          {shadow_pos, shadow_bit} = ptr + cnt;
        end
      end
      REQ_READ_BYTE: begin
        r.value = FIELD_W'(shadow_mem[shadow_pos]);
        shadow_pos = shadow_pos + 12'd1;
      end
      REQ_BACK_BITS: {shadow_pos, shadow_bit} = ptr - cnt;
      default: ;
    endcase
    r.boundary = 3'd0 - shadow_bit;
    pending_fields.push_back(r);
  endfunction

  task automatic send_item(logic [2:0] code, logic [CNT_W-1:0] cnt,
                           logic [ADDR_W-1:0] addr, logic [7:0] data);
    int gap;
    gap = send_idle ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type     <= code;
    bit_count    <= cnt;
    byte_address <= addr;
    load_data    <= data;
    req_valid    <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_field_result(code, cnt, addr, data);
    beats_sent++;
  endtask

  // window bytes at the read position must hold loaded data
  task automatic prime_window();
    logic [ADDR_W-1:0] a;
    int i;
    for (i = 0; i < 3; i++) begin
      a = shadow_pos + ADDR_W'(i);
      if (!shadow_loaded[a])
        send_item(REQ_LOAD, CNT_W'($urandom), a, 8'($urandom));
    end
  endtask

  task automatic read_bits(logic [CNT_W-1:0] cnt);
    prime_window();
    send_item(REQ_READ_BITS, cnt, ADDR_W'($urandom), 8'($urandom));
  endtask

  task automatic read_byte();
    prime_window();
    send_item(REQ_READ_BYTE, CNT_W'($urandom), ADDR_W'($urandom), 8'($urandom));
  endtask

  task automatic back_bits(logic [CNT_W-1:0] cnt);
    send_item(REQ_BACK_BITS, cnt, ADDR_W'($urandom), 8'($urandom));
  endtask

  task automatic set_pos(logic [ADDR_W-1:0] addr);
    send_item(REQ_SET_POS, CNT_W'($urandom), addr, 8'($urandom));
  endtask

  task automatic load_byte(logic [ADDR_W-1:0] addr, logic [7:0] data);
    send_item(REQ_LOAD, CNT_W'($urandom), addr, data);
  endtask

  task automatic wait_all_results();
    while (pending_fields.size() != 0) @(posedge clk);
  endtask

  // load a short run, point at it, then parse fields from that position
  task automatic run_stream_sequence();
    logic [ADDR_W-1:0] base;
    int len, nops, i, pick;
    base = ADDR_W'($urandom);
    len  = $urandom_range(3, 12);
    for (i = 0; i < len; i++)
      load_byte(base + ADDR_W'(i), 8'($urandom));
    set_pos(base);
    nops = $urandom_range(2, 8);
    for (i = 0; i < nops; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        6: read_bits($urandom_range(0, 1) ? '0
                     : CNT_W'($urandom_range(READ_BITS_MAX + 1, CNT_MAX)));
        7: read_byte();
        8: back_bits(CNT_W'($urandom_range(1, 24)));
        9: back_bits(CNT_W'($urandom_range(0, CNT_MAX)));
        default: read_bits(CNT_W'($urandom_range(1, READ_BITS_MAX)));
      endcase
    end
  endtask

  task automatic send_noise_item();
    logic [2:0] code;
    code = 3'($urandom_range(0, REQ_CODE_MAX));
    case (code)
      REQ_LOAD:      load_byte(ADDR_W'($urandom), 8'($urandom));
      REQ_SET_POS:   set_pos(ADDR_W'($urandom));
      REQ_READ_BITS: read_bits($urandom_range(0, 1) ? CNT_W'($urandom)
                               : CNT_W'($urandom_range(0, READ_BITS_MAX)));
      REQ_READ_BYTE: read_byte();
      REQ_BACK_BITS: back_bits(CNT_W'($urandom));
      default: send_item(code, CNT_W'($urandom), ADDR_W'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic run_mixed_traffic(int n_beats);
    int start;
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      if ($urandom_range(0, 9) < 7)
        run_stream_sequence();
      else
        send_noise_item();
    end
  endtask

  task automatic test_directed_edges();
    load_byte(12'd0, 8'hff);
    load_byte(12'd1, 8'h00);
    load_byte(12'd2, 8'ha5);
    load_byte(12'hfff, 8'h5a);
    set_pos(12'd0);
    read_bits(15'd0);
    read_bits(15'(READ_BITS_MAX));
    read_bits(15'd1);
    read_bits(15'(READ_BITS_MAX + 1));
    read_bits(15'(CNT_MAX));
    read_byte();
    back_bits(15'd0);
    back_bits(15'd9);
    back_bits(15'(CNT_MAX));
    set_pos(12'hfff);
    read_bits(15'(READ_BITS_MAX));
    set_pos(12'hfff);
    read_byte();
    back_bits(15'd1);
    read_bits(15'd3);
    send_item(REQ_BACK_BITS + 3'd1, 15'(CNT_MAX), 12'hfff, 8'hff);
    send_item(REQ_CODE_MAX, '0, '0, '0);
  endtask

  task automatic test_stream_traffic(int n_beats);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    run_mixed_traffic(n_beats);
  endtask

  task automatic test_fill_and_stall();
    send_idle = 1'b0;
    hold_off_left = 60;
    run_mixed_traffic(30);
    send_idle = 1'b1;
    req_valid <= 1'b0;
    wait_all_results();
  endtask

  task automatic test_no_idle_stretch(int n_beats);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    run_mixed_traffic(n_beats);
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin : result_monitor
    field_result_t want;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        results_checked++;
        if (pending_fields.size() == 0) begin
          report_mismatch("result beat with nothing pending");
        end else begin
          want = pending_fields.pop_front();
          if (field_value !== want.value)
            report_mismatch($sformatf("field_value got %h want %h", field_value, want.value));
          if (bits_to_boundary !== want.boundary)
            report_mismatch($sformatf("bits_to_boundary got %0d want %0d",
                                      bits_to_boundary, want.boundary));
          if (read_error !== want.err)
            report_mismatch($sformatf("read_error got %b want %b", read_error, want.err));
        end
        hold = recv_idle ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (hold_off_left > 0) begin
        res_stall <= 1'b1;
        hold_off_left--;
      end else if (hold > 0) begin
        res_stall <= 1'b1;
        hold--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  initial begin : test_sequence
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_stream_traffic(300);
    test_fill_and_stall();
    test_no_idle_stretch(120);
    test_stream_traffic(350);
    req_valid <= 1'b0;
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_fields.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_fields.size()));
    $display("summary: %0d request beats, %0d result beats checked, %0d mismatches",
             beats_sent, results_checked, mismatch_count);
    $display("summary: edge fields, wrapped windows, stream parsing, noise, fill under stall");
    if (mismatch_count == 0)
      $display("[bitstream_field_reader] OK");
    else
      $display("[bitstream_field_reader] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bfr_pkg.sv
rtl/bitstream_field_reader.sv
tb/sv/tb_top.sv
